@@ sv/wgm_pkg.sv @@
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants of the wildcard glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

  // Pattern capacity and derived widths
  localparam int PAT_MAX = 32;
  localparam int POS_W   = PAT_MAX + 1;                         // active position set
  localparam int LEN_W   = $clog2(PAT_MAX + 1);                 // 0..PAT_MAX
  localparam int IDX_W   = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1; // pattern entry index

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_BYTE   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  // Classified command as held in the queue
  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       is_star;
    logic       is_qmark;
    logic       ends;      // item closes a subject and carries a verdict
  } cmd_t;

endpackage

@@ sv/wgm_front.sv @@
// ----------------------------------------------------------------------------
// wgm_front
// Input side: decodes each incoming transaction into a queue command.
// ----------------------------------------------------------------------------
module wgm_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_op,
  input  logic [7:0]          in_char_value,
  input  logic                in_last,
  output logic                push_valid,
  output wgm_pkg::cmd_t       push_cmd,
  input  logic                q_full
);

  wgm_pkg::op_t op;

  always_comb begin
    op                = wgm_pkg::op_t'(in_op);
    push_cmd.op       = op;
    push_cmd.ch       = in_char_value;
    push_cmd.is_star  = (in_char_value == wgm_pkg::CH_STAR);
    push_cmd.is_qmark = (in_char_value == wgm_pkg::CH_QMARK);
    case (op)
      wgm_pkg::OP_BYTE: push_cmd.ends = in_last;
      wgm_pkg::OP_END:  push_cmd.ends = 1'b1;
      default:          push_cmd.ends = 1'b0;
    endcase
  end

  assign push_valid = in_valid;
  assign in_stall   = q_full;

endmodule

@@ sv/wgm_queue.sv @@
// ----------------------------------------------------------------------------
// wgm_queue
// Short command FIFO decoupling the decode side from the match engine.
// ----------------------------------------------------------------------------
module wgm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  wgm_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          pop_valid,
  input  logic          pop_ready,
  output wgm_pkg::cmd_t pop_cmd
);

  localparam int PtrW = wgm_pkg::QPTR_W;
  localparam int CntW = wgm_pkg::QCNT_W;

  wgm_pkg::cmd_t mem [wgm_pkg::QDEPTH];

  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            push, pop;

  assign full      = (cnt_r == CntW'(wgm_pkg::QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign push      = push_valid & ~full;
  assign pop       = pop_valid & pop_ready;
  assign pop_cmd   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? PtrW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? PtrW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push & ~pop) begin
      cnt_nxt = CntW'(cnt_r + 1'b1);
    end else if (pop & ~push) begin
      cnt_nxt = CntW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ sv/wgm_back.sv @@
// ----------------------------------------------------------------------------
// wgm_back
// Match engine: pattern store, active position set and result register.
// ----------------------------------------------------------------------------
module wgm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  wgm_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_done_res,
  output logic          out_matched,
  output logic          out_pattern_overflow
);

  localparam int PatMax = wgm_pkg::PAT_MAX;
  localparam int PosW   = wgm_pkg::POS_W;
  localparam int LenW   = wgm_pkg::LEN_W;
  localparam int IdxW   = wgm_pkg::IDX_W;

  // Pattern store, one cell per position; no reset, masked by length
  logic [7:0]        pat_char_r  [PatMax];
  logic [PatMax-1:0] pat_star_r;
  logic [PatMax-1:0] pat_q_r;
  logic              pat_we;
  logic [IdxW-1:0]   pat_widx;

  logic [LenW-1:0] pat_len_r, pat_len_nxt;
  logic [PosW-1:0] active_r, active_nxt;
  logic [PosW-1:0] start_r, start_nxt;     // start position closed over stars
  logic            open_r, open_nxt;
  logic            ovf_r, ovf_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            out_done_r, out_matched_r, out_ovf_r;
  logic            res_done, res_matched;

  logic            pop;
  logic [PatMax-1:0] in_pat;
  logic [PosW-1:0] seeds, prop, closed;
  logic [PosW:0]   add_a, add_b, carry;
  logic [LenW-1:0] next_pos;

  assign q_ready = ~out_valid_r | ~out_stall;
  assign pop     = q_valid & q_ready;

  // One step of the position-set automaton. Stars keep themselves, matching
  // cells hand on to the next position; the star closure is a carry chain
  // (generate = seed, propagate = star just below) done with one adder.
  always_comb begin
    seeds = '0;
    prop  = '0;
    for (int i = 0; i < PatMax; i++) begin
      in_pat[i] = (LenW'(i) < pat_len_r);
      if (active_r[i] & in_pat[i]) begin
        if (pat_star_r[i]) begin
          seeds[i] = 1'b1;
        end else if (pat_q_r[i] || (pat_char_r[i] == q_cmd.ch)) begin
          seeds[i+1] = 1'b1;
        end
      end
      prop[i+1] = pat_star_r[i] & in_pat[i];
    end
    add_a  = {1'b0, seeds | prop};
    add_b  = {1'b0, seeds};
    carry  = (add_a + add_b) ^ add_a ^ add_b;
    closed = carry[PosW:1];
  end

  always_comb begin
    pat_len_nxt = pat_len_r;
    active_nxt  = active_r;
    start_nxt   = start_r;
    open_nxt    = open_r;
    ovf_nxt     = ovf_r;
    pat_we      = 1'b0;
    pat_widx    = pat_len_r[IdxW-1:0];
    next_pos    = LenW'(pat_len_r + 1'b1);
    res_done    = 1'b0;
    res_matched = 1'b0;
    if (pop) begin
      case (q_cmd.op)
        wgm_pkg::OP_CLEAR: begin
          pat_len_nxt = '0;
          ovf_nxt     = 1'b0;
          open_nxt    = 1'b0;
          start_nxt   = PosW'(1);
          active_nxt  = PosW'(1);
        end
        wgm_pkg::OP_APPEND: begin
          if (pat_len_r < LenW'(PatMax)) begin
            pat_we      = 1'b1;
            pat_len_nxt = next_pos;
            if (start_r[pat_len_r] & q_cmd.is_star) begin
              start_nxt[next_pos] = 1'b1;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          open_nxt   = 1'b0;
          active_nxt = start_nxt;
        end
        wgm_pkg::OP_BYTE: begin
          if (q_cmd.ends) begin
            res_done    = 1'b1;
            res_matched = closed[pat_len_r];
            open_nxt    = 1'b0;
            active_nxt  = start_r;
          end else begin
            open_nxt   = 1'b1;
            active_nxt = closed;
          end
        end
        default: begin
          res_done    = 1'b1;
          res_matched = active_r[pat_len_r];
          open_nxt    = 1'b0;
          active_nxt  = start_r;
        end
      endcase
    end
    out_valid_nxt = pop | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r   <= '0;
      active_r    <= PosW'(1);
      start_r     <= PosW'(1);
      open_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pat_len_r   <= pat_len_nxt;
      active_r    <= active_nxt;
      start_r     <= start_nxt;
      open_r      <= open_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_char_r[pat_widx] <= q_cmd.ch;
      pat_star_r[pat_widx] <= q_cmd.is_star;
      pat_q_r[pat_widx]    <= q_cmd.is_qmark;
    end
    if (pop) begin
      out_done_r    <= res_done;
      out_matched_r <= res_matched;
      out_ovf_r     <= ovf_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_done_res         = out_done_r;
  assign out_matched          = out_matched_r;
  assign out_pattern_overflow = out_ovf_r;

`ifndef SYNTHESIS
  logic [PosW-1:0] len_mask;
  always_comb begin
    for (int j = 0; j < PosW; j++) begin
      len_mask[j] = (LenW'(j) <= pat_len_r);
    end
  end

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    pat_len_r <= LenW'(PatMax))
    else $error("pattern length beyond capacity");

  a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    !open_r |-> (active_r == start_r))
    else $error("active set not reloaded outside a subject");

  a_active_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r & ~len_mask) == '0)
    else $error("active position beyond pattern end");

  a_verdict_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_done_r) |-> !out_matched_r)
    else $error("match reported without a finished subject");
`endif

endmodule

@@ sv/wildcard_glob_matcher_top.sv @@
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_top
// Streaming glob matcher ('*' any run, '?' any byte) over a loaded pattern.
// Flow: with the queue empty, an accepted transaction is written into the
//   queue, and the engine then pops it and loads the output register;
//   commands queued ahead of it are retired first.
// Throughput: one transaction per cycle; every pattern position steps in
//   parallel, and in_stall rises only when the 4-entry command queue fills.
// Reset: synchronous, active low; empty pattern, no overflow, no result.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_top (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [7:0] in_char_value,
  input  logic       in_last,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_done_res,
  output logic       out_matched,
  output logic       out_pattern_overflow
);

  // Front to queue
  logic          push_valid;
  wgm_pkg::cmd_t push_cmd;
  logic          q_full;

  // Queue to back
  logic          q_valid;
  logic          q_ready;
  wgm_pkg::cmd_t q_cmd;

  // Decode: op and byte become a command with the star and question-mark
  // tests and the end-of-subject flag worked out ahead of the engine.
  wgm_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_char_value (in_char_value),
    .in_last       (in_last),
    .push_valid    (push_valid),
    .push_cmd      (push_cmd),
    .q_full        (q_full)
  );

  // Decoupling queue: the input side keeps taking transactions while the
  // result register is held by out_stall.
  wgm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // Engine: pattern cells, active position set and registered result.
  // One command retires per cycle whenever the result register is free
  // or being emptied.
  wgm_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_ready              (q_ready),
    .q_cmd                (q_cmd),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_done_res         (out_done_res),
    .out_matched          (out_matched),
    .out_pattern_overflow (out_pattern_overflow)
  );

endmodule
